// ===== rtl/bbr_pkg.sv =====
// Shared types, constants and helpers for the bitstream bit reader.
// Used by bbr_ctrl, bbr_datapath and the bitstream_bit_reader top level.
package bbr_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int MAX_COUNT   = 24;

    typedef enum logic [2:0] {
        OP_RESTART = 3'd0,
        OP_LOAD    = 3'd1,
        OP_GET     = 3'd2,
        OP_SHOW    = 3'd3,
        OP_SKIP    = 3'd4,
        OP_BYTE    = 3'd5,
        OP_ALIGN   = 3'd6,
        OP_MORE    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_STEP = 2'd2
    } t_state;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
        logic [4:0] bit_count;
    } t_in_beat;

    typedef struct packed {
        logic [23:0] value;
        logic [15:0] remaining_bits;
        logic        end_of_stream;
        logic        no_bits_error;
        logic        more_data;
        logic        store_full;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic fill;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic need_fill;
    } t_status;

    // Low n bits set, n in 0..63.
    function automatic logic [31:0] low_mask(input logic [5:0] n);
        logic [31:0] m;
        if (n >= 6'd32) begin
            m = 32'hffff_ffff;
        end else begin
            m = (32'd1 << n) - 32'd1;
        end
        return m;
    endfunction

endpackage

// ===== rtl/bbr_ctrl.sv =====
// Sequencer of the bit reader: accept, memory read wait, refill steps, execute.
// Depends on bbr_pkg; drives commands into bbr_datapath.
module bbr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    input  bbr_pkg::t_status i_status,
    output bbr_pkg::t_cmd   o_cmd
);
    import bbr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (i_status.need_fill) begin
                    n_state = ST_READ;
                end else if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            ST_READ: begin
                o_cmd = '0;
            end
            ST_STEP: begin
                o_cmd.fill = i_status.need_fill;
                o_cmd.exec = !i_status.need_fill && w_slot_free;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.exec) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_exec_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> (!r_out_valid || !i_out_stall))
        else $error("result written over an unread beat");
    a_load_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_READ))
        else $error("accepted beat did not start a memory read");
    a_fill_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fill |=> (!o_cmd.fill && !o_cmd.exec))
        else $error("refill step not followed by a read wait");
`endif

endmodule

// ===== rtl/bbr_datapath.sv =====
// Byte store, window, counters and result register of the bit reader.
// Depends on bbr_pkg; sequenced by bbr_ctrl.
module bbr_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbr_pkg::t_in_beat i_in_beat,
    input  bbr_pkg::t_cmd     i_cmd,
    output bbr_pkg::t_status  o_status,
    output bbr_pkg::t_out_beat o_out_beat
);
    import bbr_pkg::*;

    logic [7:0]       mem [STORE_BYTES];
    logic [7:0]       r_rd;

    t_op              r_op;
    logic [7:0]       r_data;
    logic [4:0]       r_count;

    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_rp, n_rp;
    logic [5:0]       r_held, n_held;
    logic [31:0]      r_win, n_win;
    logic             r_err, n_err;
    t_out_beat        r_out;

    logic             w_we;
    logic [5:0]       w_cnt;
    logic [LEN_W-1:0] w_left;
    logic [5:0]       w_aligned;
    logic [31:0]      w_value;
    logic [31:0]      w_last;
    logic             w_eos, w_more, w_full;
    logic [15:0]      w_rem;
    logic             w_bit_op;

    assign w_cnt    = {1'b0, r_count};
    assign w_left   = r_len - r_rp;
    assign w_bit_op = (r_op == OP_GET) || (r_op == OP_SHOW) || (r_op == OP_SKIP);
    assign o_status.need_fill = w_bit_op && (w_cnt > r_held) && (r_rp < r_len);
    assign w_we = i_cmd.exec && (r_op == OP_LOAD) && (r_len < LEN_W'(STORE_BYTES));

    // Single port: a load writes, every other cycle reads at the read position.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_len[ADDR_W-1:0]] <= r_data;
        end else begin
            r_rd <= mem[r_rp[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_in_beat.op);
            r_data  <= i_in_beat.data_byte;
            r_count <= (i_in_beat.bit_count > 5'(MAX_COUNT)) ? 5'(MAX_COUNT)
                                                            : i_in_beat.bit_count;
        end
    end

    always_comb begin
        n_len     = r_len;
        n_rp      = r_rp;
        n_held    = r_held;
        n_win     = r_win;
        n_err     = r_err;
        w_value   = '0;
        w_eos     = 1'b0;
        w_more    = 1'b0;
        w_full    = 1'b0;
        w_last    = '0;
        w_aligned = {r_held[5:3], 3'b000};
        if (i_cmd.fill) begin
            n_win  = {r_win[23:0], r_rd};
            n_held = r_held + 6'd8;
            n_rp   = r_rp + 1'b1;
        end else if (i_cmd.exec) begin
            unique case (r_op)
                OP_RESTART: begin
                    n_len  = '0;
                    n_rp   = '0;
                    n_held = '0;
                    n_win  = '0;
                    n_err  = 1'b0;
                end
                OP_LOAD: begin
                    if (r_len < LEN_W'(STORE_BYTES)) begin
                        n_len = r_len + 1'b1;
                    end else begin
                        w_full = 1'b1;
                    end
                end
                OP_GET: begin
                    if (w_cnt > r_held) begin
                        n_err = 1'b1;
                    end else begin
                        n_held  = r_held - w_cnt;
                        w_value = (r_win >> n_held) & low_mask(w_cnt);
                    end
                end
                OP_SHOW: begin
                    // pad with zeros past the end
                    if (w_cnt <= r_held) begin
                        w_value = (r_win >> (r_held - w_cnt)) & low_mask(w_cnt);
                    end else begin
                        w_value = (r_win << (w_cnt - r_held)) & low_mask(w_cnt);
                    end
                end
                OP_SKIP: begin
                    if (w_cnt > r_held) begin
                        n_err  = 1'b1;
                        n_held = '0;
                    end else begin
                        n_held = r_held - w_cnt;
                    end
                end
                OP_BYTE: begin
                    if (r_held >= 6'd8) begin
                        w_value = (r_win >> (w_aligned - 6'd8)) & 32'h0000_00ff;
                        n_held  = w_aligned - 6'd8;
                    end else begin
                        // drop partial bits, take the next stored byte
                        n_held = '0;
                        if (r_rp >= r_len) begin
                            w_eos = 1'b1;
                        end else begin
                            w_value = {24'd0, r_rd};
                            n_rp    = r_rp + 1'b1;
                        end
                    end
                end
                OP_ALIGN: begin
                    w_value = {29'd0, r_held[2:0]};
                    n_held  = w_aligned;
                end
                OP_MORE: begin
                    if ((w_left >= LEN_W'(2)) ||
                        (({w_left, 3'b000} + 16'(r_held)) >= 16'd9)) begin
                        w_more = 1'b1;
                    end else if ((w_left == '0) && (r_held == '0)) begin
                        w_more = 1'b0;
                    end else begin
                        // one byte left and nothing held: pull it in first
                        if (w_left == LEN_W'(1)) begin
                            n_win  = {r_win[23:0], r_rd};
                            n_held = r_held + 6'd8;
                            n_rp   = r_rp + 1'b1;
                        end
                        w_last = n_win & low_mask(n_held);
                        w_more = (w_last != (32'd1 << (n_held - 6'd1)));
                    end
                end
            endcase
        end
        w_rem = {n_len - n_rp, 3'b000} + 16'(n_held);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_rp   <= '0;
            r_held <= '0;
            r_win  <= '0;
            r_err  <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_rp   <= n_rp;
            r_held <= n_held;
            r_win  <= n_win;
            r_err  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out.value          <= w_value[23:0];
            r_out.remaining_bits <= w_rem;
            r_out.end_of_stream  <= w_eos;
            r_out.no_bits_error  <= n_err;
            r_out.more_data      <= w_more;
            r_out.store_full     <= w_full;
        end
    end

    assign o_out_beat = r_out;

`ifndef SYNTHESIS
    a_rp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_len)
        else $error("read position past stored length");
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= 6'd31)
        else $error("window holds more than 31 bits");
    a_fill_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> (r_rp < r_len))
        else $error("refill past end of stored data");
`endif

endmodule

// ===== rtl/bitstream_bit_reader.sv =====
// Top level of the bitstream bit reader: controller plus datapath.
// Depends on bbr_pkg, bbr_ctrl and bbr_datapath.
//
// Usage: send a restart beat, then one load beat per payload byte, then
// read requests (get, show, skip, get byte, align, more data). Every
// request beat returns exactly one result beat.
// Input channel: i_in_valid / o_in_stall with payload i_in_beat; a beat is
// taken on a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with payload o_out_beat.
// Sequencing: one request is worked at a time. After acceptance a request
// waits in the read state, then takes a refill step and another read wait
// for each of k (0..3) bytes refilled into the 32-bit window; its result
// is registered in the execute step. Each refill byte costs a single-port
// store read plus a shift; the next request is accepted in the next cycle.
// The result sits in an output register, so the next request is accepted
// while it waits; a request whose result is ready holds until that
// register is free when the receiver stalls.
// Reset (synchronous, active low) empties the store and window and clears
// the sticky error; store contents are not cleared and need no pass.
module bitstream_bit_reader (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bbr_pkg::t_in_beat   i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bbr_pkg::t_out_beat  o_out_beat
);
    import bbr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    bbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bbr_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_beat  (i_in_beat),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_beat (o_out_beat)
    );

endmodule

// ===== tb/bitstream_bit_reader_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bitstream_bit_reader: queued request beats, a
// per-request predictor of the reader state and a result checker. Depends on bbr_pkg.
module bitstream_bit_reader_tb;
    import bbr_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int QUIET_TAIL   = 80;
    localparam int RANDOM_BEATS = 600;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_beat   i_in_beat = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_beat  o_out_beat;

    t_in_beat   pending_requests[$];
    t_out_beat  expected_results[$];
    int         mismatches = 0;
    int         cycle_count = 0;
    int         in_gap_left = 0;
    int         out_gap_left = 0;

    // Predicted reader state.
    bit [7:0]   nal_bytes [STORE_BYTES];
    int         nal_len = 0;
    int         rd_pos = 0;
    int         bits_held = 0;
    logic [31:0] bit_win = '0;
    logic       err_flag = 1'b0;

    bitstream_bit_reader i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] ones(input int n);
        logic [31:0] m;
        if (n >= 32) begin
            m = '1;
        end else begin
            m = (32'd1 << n) - 32'd1;
        end
        return m;
    endfunction

    function automatic void pull_byte();
        bit_win = {bit_win[23:0], nal_bytes[rd_pos]};
        rd_pos++;
        bits_held += 8;
    endfunction

    function automatic void refill_window(input int n);
        while (n > bits_held && rd_pos < nal_len) begin
            pull_byte();
        end
    endfunction

    function automatic t_out_beat predict_read_result(input t_in_beat req);
        t_out_beat res;
        int n;
        int left;
        int rem;
        logic [31:0] tail;
        res = '0;
        n = req.bit_count;
        if (n > MAX_COUNT) n = MAX_COUNT;
        case (t_op'(req.op))
            OP_RESTART: begin
                nal_len = 0;
                rd_pos = 0;
                bits_held = 0;
                bit_win = '0;
                err_flag = 1'b0;
            end
            OP_LOAD: begin
                if (nal_len < STORE_BYTES) begin
                    nal_bytes[nal_len] = req.data_byte;
                    nal_len++;
                end else begin
                    res.store_full = 1'b1;
                end
            end
            OP_GET: begin
                refill_window(n);
                if (n > bits_held) begin
                    err_flag = 1'b1;
                end else begin
                    bits_held -= n;
                    res.value = 24'((bit_win >> bits_held) & ones(n));
                end
            end
            OP_SHOW: begin
                refill_window(n);
                // pad with zeros past the end of the payload
                if (n <= bits_held) begin
                    res.value = 24'((bit_win >> (bits_held - n)) & ones(n));
                end else begin
                    res.value = 24'((bit_win << (n - bits_held)) & ones(n));
                end
            end
            OP_SKIP: begin
                refill_window(n);
                if (n > bits_held) begin
                    err_flag = 1'b1;
                    bits_held = 0;
                end else begin
                    bits_held -= n;
                end
            end
            OP_BYTE: begin
                if (bits_held >= 8) begin
                    bits_held = bits_held & ~7;
                    res.value = 24'((bit_win >> (bits_held - 8)) & 32'hff);
                    bits_held -= 8;
                end else begin
                    bits_held = 0;
                    if (rd_pos >= nal_len) begin
                        res.end_of_stream = 1'b1;
                    end else begin
                        res.value = 24'(nal_bytes[rd_pos]);
                        rd_pos++;
                    end
                end
            end
            OP_ALIGN: begin
                res.value = 24'(bits_held & 7);
                bits_held = bits_held & ~7;
            end
            OP_MORE: begin
                left = nal_len - rd_pos;
                if (left >= 2 || left * 8 + bits_held >= 9) begin
                    res.more_data = 1'b1;
                end else if (left != 0 || bits_held != 0) begin
                    if (left == 1) pull_byte();
                    // only the stop bit left means no more data
                    tail = bit_win & ones(bits_held);
                    res.more_data = (tail != (32'd1 << (bits_held - 1)));
                end
            end
        endcase
        rem = bits_held + 8 * (nal_len - rd_pos);
        if (rem > 65535) rem = 65535;
        res.remaining_bits = 16'(rem);
        res.no_bits_error = err_flag;
        return res;
    endfunction

    task automatic queue_request(input t_op op, input int unsigned data,
                                 input int unsigned count);
        t_in_beat beat;
        beat.op = op;
        beat.data_byte = data[7:0];
        beat.bit_count = count[4:0];
        pending_requests.push_back(beat);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_read_result(i_in_beat));
            end
            // hold the beat while stalled
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap_left > 0) begin
                    in_gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() > QUIET_TAIL &&
                             $urandom_range(0, 7) == 0) begin
                    in_gap_left = $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_beat <= pending_requests.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin : monitor
        t_out_beat want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    compare_field("value", o_out_beat.value, want.value);
                    compare_field("remaining_bits", o_out_beat.remaining_bits,
                                  want.remaining_bits);
                    compare_field("end_of_stream", o_out_beat.end_of_stream,
                                  want.end_of_stream);
                    compare_field("no_bits_error", o_out_beat.no_bits_error,
                                  want.no_bits_error);
                    compare_field("more_data", o_out_beat.more_data, want.more_data);
                    compare_field("store_full", o_out_beat.store_full, want.store_full);
                end
            end
            if (out_gap_left > 0) begin
                out_gap_left--;
                i_out_stall <= 1'b1;
            end else if (pending_requests.size() > QUIET_TAIL &&
                         $urandom_range(0, 7) == 0) begin
                out_gap_left = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int base;
        int nbytes;
        int nreq;
        int pick;
        int unsigned b;
        int unsigned cnt;
        t_op op;

        // empty payload corners
        queue_request(OP_RESTART, $urandom, $urandom);
        queue_request(OP_GET, $urandom, 1);
        queue_request(OP_SHOW, $urandom, 0);
        queue_request(OP_BYTE, $urandom, $urandom);
        queue_request(OP_MORE, $urandom, $urandom);
        queue_request(OP_ALIGN, $urandom, $urandom);
        // four bytes: full get, padded show, stop bit alone, skip past end
        queue_request(OP_RESTART, $urandom, $urandom);
        queue_request(OP_LOAD, 8'hff, 0);
        queue_request(OP_LOAD, 8'h00, 31);
        queue_request(OP_LOAD, 8'h5a, 0);
        queue_request(OP_LOAD, 8'h80, 31);
        queue_request(OP_GET, $urandom, 24);
        queue_request(OP_SHOW, $urandom, 31);
        queue_request(OP_SKIP, $urandom, 0);
        queue_request(OP_GET, $urandom, 0);
        queue_request(OP_MORE, $urandom, $urandom);
        queue_request(OP_BYTE, $urandom, $urandom);
        queue_request(OP_MORE, $urandom, $urandom);
        queue_request(OP_SKIP, $urandom, 5);
        // partial byte: align count, then a byte read of the next stored byte
        queue_request(OP_RESTART, $urandom, $urandom);
        queue_request(OP_LOAD, 8'h13, 0);
        queue_request(OP_LOAD, 8'h01, 0);
        queue_request(OP_GET, $urandom, 3);
        queue_request(OP_ALIGN, $urandom, $urandom);
        queue_request(OP_BYTE, $urandom, $urandom);

        // fill the store to the brim, then overflow it
        queue_request(OP_RESTART, $urandom, $urandom);
        for (int i = 0; i < STORE_BYTES + 3; i++) begin
            queue_request(OP_LOAD, $urandom, $urandom);
        end
        queue_request(OP_MORE, $urandom, $urandom);
        queue_request(OP_GET, $urandom, 24);
        queue_request(OP_SKIP, $urandom, 31);
        queue_request(OP_BYTE, $urandom, $urandom);
        queue_request(OP_SHOW, $urandom, 17);
        queue_request(OP_ALIGN, $urandom, $urandom);

        // random sessions: mostly restart, short payload, then reads
        base = pending_requests.size();
        while (pending_requests.size() < base + RANDOM_BEATS) begin
            if ($urandom_range(0, 9) != 0) queue_request(OP_RESTART, $urandom, $urandom);
            pick = $urandom_range(0, 19);
            nbytes = (pick < 15) ? $urandom_range(0, 10) :
                     (pick < 19) ? $urandom_range(11, 40) : 0;
            for (int i = 0; i < nbytes; i++) begin
                b = $urandom;
                // end some payloads on a stop bit with zero padding
                if (i == nbytes - 1 && $urandom_range(0, 1) == 1) begin
                    b = (($urandom | 1) << $urandom_range(0, 7)) & 8'hff;
                end
                queue_request(OP_LOAD, b, $urandom);
            end
            nreq = $urandom_range(1, 16);
            for (int i = 0; i < nreq; i++) begin
                pick = $urandom_range(0, 19);
                op = (pick == 0) ? OP_LOAD :
                     (pick == 1) ? OP_RESTART : t_op'(3'($urandom_range(2, 7)));
                cnt = ($urandom_range(0, 6) == 0) ? $urandom_range(25, 31) :
                                                   $urandom_range(0, 24);
                queue_request(op, $urandom, cnt);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_in_valid) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bbr_pkg.sv
rtl/bbr_ctrl.sv
rtl/bbr_datapath.sv
rtl/bitstream_bit_reader.sv
tb/bitstream_bit_reader_tb.sv
